/* rtl/core/sms_pkg.sv */
// Shared types and constants for the motion-safety supervisor.
// No dependencies; imported by the interfaces and all core modules.

package sms_pkg;

  localparam int unsigned TicksW = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TicksW-1:0] TicksMax   = '1;
  localparam logic [TicksW-1:0] TicksReset = TicksW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE_TICKS = 1'b0,
    CFG_ACTIVE_LEVEL   = 1'b1
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_TICK           = 3'd0,
    KIND_START          = 3'd1,
    KIND_STOP           = 3'd2,
    KIND_ESTOP          = 3'd3,
    KIND_BEGIN_MOTION   = 3'd4,
    KIND_FINISH_MOTION  = 3'd5,
    KIND_IMMEDIATE_MOVE = 3'd6
  } kind_e;

  typedef enum logic [ModeW-1:0] {
    MODE_BOOT    = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_ARMED   = 3'd2,
    MODE_MOVING  = 3'd3,
    MODE_STOPPED = 3'd4,
    MODE_ESTOP   = 3'd5,
    MODE_FAULT   = 3'd6
  } mode_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INVALID = 1'b1
  } status_e;

  typedef struct packed {
    logic stable;
    logic changed;
  } sms_deb_t;

endpackage

/* rtl/core/sms_if.sv */
// Request and response channel interfaces for the supervisor.
// Depends on sms_pkg for field widths.

interface sms_req_if import sms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic             stop_pin;
  logic             limit_pin;

  modport source (output valid, kind, stop_pin, limit_pin, input ready);
  modport sink   (input valid, kind, stop_pin, limit_pin, output ready);
endinterface

interface sms_rsp_if import sms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [ModeW-1:0] mode_now;
  logic             motion_allowed;
  logic             in_estop;
  logic             limit_asserted;
  logic             limit_changed;
  logic             stop_tripped;

  modport source (output valid, status, mode_now, motion_allowed, in_estop,
                  limit_asserted, limit_changed, stop_tripped, input ready);
  modport sink   (input valid, status, mode_now, motion_allowed, in_estop,
                  limit_asserted, limit_changed, stop_tripped, output ready);
endinterface

/* rtl/core/sms_debounce.sv */
// Pin debouncer: last raw level, stable level and saturating hold count.
// Depends on sms_pkg; advances only on tick requests.

module sms_debounce import sms_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              raw_i,
  input  logic [TicksW-1:0] ticks_i,
  output sms_deb_t          deb_o
);

  logic              last_q, last_d;
  logic              stable_q, stable_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;
  logic [TicksW-1:0] elapsed_inc;

  always_comb begin
    last_d      = last_q;
    stable_d    = stable_q;
    elapsed_d   = elapsed_q;
    elapsed_inc = (elapsed_q == TicksMax) ? elapsed_q : elapsed_q + TicksW'(1);
    deb_o.changed = 1'b0;
    if (raw_i != last_q) begin
      last_d    = raw_i;
      elapsed_d = '0;
    end else begin
      elapsed_d = elapsed_inc;
      if ((raw_i != stable_q) && (elapsed_inc >= ticks_i)) begin
        stable_d      = raw_i;
        deb_o.changed = 1'b1;
      end
    end
    // hold the stored level on anything but a tick
    deb_o.stable = step_i ? stable_d : stable_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      stable_q  <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      last_q    <= last_d;
      stable_q  <= stable_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

/* rtl/core/sms_mode.sv */
// Mode machine: applies commands and stop trips, refuses illegal commands.
// Depends on sms_pkg for request kinds, modes and status codes.

module sms_mode import sms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [KindW-1:0] kind_i,
  input  logic             stop_trip_i,
  output logic             status_o,
  output mode_e            mode_o
);

  mode_e mode_q, mode_d;

  always_comb begin
    mode_d   = mode_q;
    status_o = STATUS_OK;
    unique case (kind_i)
      KIND_TICK: begin
        if (stop_trip_i) mode_d = MODE_ESTOP;
      end
      KIND_START: begin
        if (mode_q == MODE_ESTOP || mode_q == MODE_FAULT) status_o = STATUS_INVALID;
        else mode_d = MODE_ARMED;
      end
      KIND_STOP: begin
        if (mode_q == MODE_ESTOP) status_o = STATUS_INVALID;
        else mode_d = MODE_STOPPED;
      end
      KIND_ESTOP: begin
        mode_d = MODE_ESTOP;
      end
      KIND_BEGIN_MOTION: begin
        if (mode_q != MODE_ARMED) status_o = STATUS_INVALID;
        else mode_d = MODE_MOVING;
      end
      KIND_FINISH_MOTION: begin
        if (mode_q != MODE_MOVING) status_o = STATUS_INVALID;
        else mode_d = MODE_ARMED;
      end
      KIND_IMMEDIATE_MOVE: begin
        if (mode_q != MODE_ARMED) status_o = STATUS_INVALID;
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
    mode_o = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

/* rtl/core/safety_mode_supervisor_top.sv */
// Motion-safety supervisor top level: request register, debouncers, mode machine,
// response register. Depends on sms_pkg, sms_if, sms_debounce and sms_mode.
// Each result is registered in the response register after the request register.
// Throughput: one request per cycle while the response is taken; the response register frees the input side.
// Reset: asynchronous, active low; mode idle, debouncers cleared,
// debounce_ticks 3, active_level 1.

module safety_mode_supervisor_top import sms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TicksW-1:0]   cfg_wdata_i,
  sms_req_if.sink             req_i,
  sms_rsp_if.source           rsp_o
);

  logic [TicksW-1:0] ticks_q;
  logic              active_q;

  logic              in_vld_q;
  logic [KindW-1:0]  kind_q;
  logic              stop_pin_q;
  logic              limit_pin_q;

  logic              out_vld_q;
  logic              status_q;
  logic [ModeW-1:0]  mode_q;
  logic              motion_q;
  logic              estop_q;
  logic              lim_act_q;
  logic              lim_chg_q;
  logic              trip_q;

  logic              adv;
  logic              step;
  logic              tick;
  logic              stop_trip;
  logic              status;
  mode_e             mode_next;
  sms_deb_t          stop_deb;
  sms_deb_t          limit_deb;

  assign adv   = !out_vld_q || rsp_o.ready;
  assign step  = in_vld_q && adv;
  assign tick  = step && (kind_q == KIND_TICK);
  assign req_i.ready = !in_vld_q || adv;

  assign stop_trip = (kind_q == KIND_TICK) && stop_deb.changed &&
                     (stop_deb.stable == active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= TicksReset;
      active_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE_TICKS: ticks_q  <= cfg_wdata_i;
        CFG_ACTIVE_LEVEL:   active_q <= cfg_wdata_i[0];
        default:            ticks_q  <= ticks_q;
      endcase
    end
  end

  sms_debounce u_stop_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (tick),
    .raw_i   (stop_pin_q),
    .ticks_i (ticks_q),
    .deb_o   (stop_deb)
  );

  sms_debounce u_limit_deb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (tick),
    .raw_i   (limit_pin_q),
    .ticks_i (ticks_q),
    .deb_o   (limit_deb)
  );

  sms_mode u_mode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .kind_i      (kind_q),
    .stop_trip_i (stop_trip),
    .status_o    (status),
    .mode_o      (mode_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q      <= req_i.kind;
      stop_pin_q  <= req_i.stop_pin;
      limit_pin_q <= req_i.limit_pin;
    end
    if (step) begin
      status_q  <= status;
      mode_q    <= mode_next;
      motion_q  <= (mode_next == MODE_ARMED);
      estop_q   <= (mode_next == MODE_ESTOP);
      lim_act_q <= (limit_deb.stable == active_q);
      lim_chg_q <= (kind_q == KIND_TICK) && limit_deb.changed;
      trip_q    <= stop_trip;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.mode_now       = mode_q;
  assign rsp_o.motion_allowed = motion_q;
  assign rsp_o.in_estop       = estop_q;
  assign rsp_o.limit_asserted = lim_act_q;
  assign rsp_o.limit_changed  = lim_chg_q;
  assign rsp_o.stop_tripped   = trip_q;

endmodule
